// File: hw/rtl/rmsq_pkg.sv
`default_nettype none

package rmsq_pkg;

  localparam int DEF_QUEUE_DEPTH = 32;
  localparam int DEF_HANDLE_BITS = 16;

  localparam int CFG_DATA_BITS = 16;
  localparam int CFG_INDEX_BITS = 1;

  localparam logic [CFG_INDEX_BITS-1:0] REG_SEND_INTERVAL = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RETRY_LIMIT   = 1'b1;

  localparam logic [15:0] SEND_INTERVAL_RESET = 16'd200;
  localparam logic [3:0]  RETRY_LIMIT_RESET   = 4'd2;
  localparam logic [15:0] TICKS_MAX           = 16'hFFFF;
  localparam logic [3:0]  ATTEMPTS_MAX        = 4'hF;

  typedef enum logic [1:0] {
    OP_PUSH      = 2'd0,
    OP_PRIO_PUSH = 2'd1,
    OP_TICK      = 2'd2,
    OP_COMPLETE  = 2'd3
  } opcode_t;

  typedef struct packed {
    opcode_t     opcode;
    logic [15:0] message_handle;
    logic        html_mode;
    logic        send_ok;
  } req_item_t;

  typedef struct packed {
    logic        issue_send;
    logic [15:0] send_handle;
    logic        send_html;
    logic        dropped;
    logic        popped;
    logic [5:0]  queue_count;
    logic        send_pending;
  } rsp_item_t;

  typedef struct packed {
    logic load;   // latch request, read head entry
    logic exec;   // apply update, load response register
  } rmsq_cmd_t;

endpackage

`default_nettype wire

// File: hw/rtl/rmsq_ctrl.sv
`default_nettype none

module rmsq_ctrl
  import rmsq_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      req_valid,
  output logic           req_ready,
  output logic           rsp_valid,
  input  wire logic      rsp_ready,
  output rmsq_cmd_t      cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // hold until the response register can take the result
        if (!rsp_valid || rsp_ready) begin
          cmd.exec   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.exec) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/rmsq_datapath.sv
`default_nettype none

module rmsq_datapath
  import rmsq_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int HANDLE_BITS = DEF_HANDLE_BITS
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire rmsq_cmd_t                 cmd,
  input  wire req_item_t                 req,
  input  wire logic                      cfg_wr_en,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_data,
  output rsp_item_t                      rsp
);

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int EXT_W = (HANDLE_BITS > 16) ? HANDLE_BITS : 16;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  typedef struct packed {
    logic [HANDLE_BITS-1:0] handle;
    logic                   html;
    logic [3:0]             attempts;
  } entry_t;

  entry_t mem [QUEUE_DEPTH];
  entry_t rd_entry;

  req_item_t        req_q;
  logic [IDX_W-1:0] head, head_next;
  logic [IDX_W-1:0] tail, tail_next;
  logic [CNT_W-1:0] count, count_next;
  logic [15:0]      elapsed, elapsed_next;
  logic             awaiting, awaiting_next;
  logic             replaced, replaced_next;
  logic [15:0]      send_interval;
  logic [3:0]       retry_limit;
  rsp_item_t        rsp_next;

  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  entry_t           mem_wdata;

  logic [EXT_W-1:0] push_ext, send_ext;
  logic [15:0]      ticks_inc;
  logic             full;
  logic [IDX_W-1:0] head_inc, head_dec, tail_inc, tail_dec;

  assign push_ext = EXT_W'(req_q.message_handle);
  assign send_ext = EXT_W'(rd_entry.handle);
  assign full     = (count == FULL_CNT);
  assign head_inc = (head == LAST_IDX) ? '0 : head + 1'b1;
  assign head_dec = (head == '0) ? LAST_IDX : head - 1'b1;
  assign tail_inc = (tail == LAST_IDX) ? '0 : tail + 1'b1;
  assign tail_dec = (tail == '0) ? LAST_IDX : tail - 1'b1;
  assign ticks_inc = (elapsed == TICKS_MAX) ? elapsed : elapsed + 16'd1;

  always_comb begin
    head_next     = head;
    tail_next     = tail;
    count_next    = count;
    elapsed_next  = elapsed;
    awaiting_next = awaiting;
    replaced_next = replaced;
    mem_we        = 1'b0;
    mem_waddr     = tail;
    mem_wdata.handle   = push_ext[HANDLE_BITS-1:0];
    mem_wdata.html     = req_q.html_mode;
    mem_wdata.attempts = '0;
    rsp_next      = '0;
    unique case (req_q.opcode)
      OP_PUSH: begin
        mem_we    = 1'b1;
        mem_waddr = tail;
        tail_next = tail_inc;
        if (full) begin
          // oldest entry goes; tail slot is the old head
          head_next        = head_inc;
          rsp_next.dropped = 1'b1;
          if (awaiting) replaced_next = 1'b1;
        end else begin
          count_next = count + 1'b1;
        end
      end
      OP_PRIO_PUSH: begin
        mem_we    = 1'b1;
        mem_waddr = head_dec;
        head_next = head_dec;
        if (full) begin
          tail_next        = tail_dec;
          rsp_next.dropped = 1'b1;
        end else begin
          count_next = count + 1'b1;
        end
        if (awaiting) replaced_next = 1'b1;
      end
      OP_TICK: begin
        elapsed_next = ticks_inc;
        if (count != '0 && !awaiting && ticks_inc >= send_interval) begin
          rsp_next.issue_send  = 1'b1;
          rsp_next.send_handle = send_ext[15:0];
          rsp_next.send_html   = rd_entry.html;
          elapsed_next  = '0;
          awaiting_next = 1'b1;
          replaced_next = 1'b0;
        end
      end
      OP_COMPLETE: begin
        if (awaiting) begin
          if (!replaced && count != '0) begin
            if (req_q.send_ok || rd_entry.attempts >= retry_limit) begin
              head_next       = head_inc;
              count_next      = count - 1'b1;
              rsp_next.popped = 1'b1;
            end else if (rd_entry.attempts < ATTEMPTS_MAX) begin
              mem_we             = 1'b1;
              mem_waddr          = head;
              mem_wdata          = rd_entry;
              mem_wdata.attempts = rd_entry.attempts + 4'd1;
            end
          end
          awaiting_next = 1'b0;
          replaced_next = 1'b0;
        end
      end
      default: ;
    endcase
    rsp_next.queue_count  = 6'(count_next);
    rsp_next.send_pending = awaiting_next;
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.load) begin
      rd_entry <= mem[head];
      req_q    <= req;
    end
    if (cmd.exec) begin
      rsp <= rsp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head          <= '0;
      tail          <= '0;
      count         <= '0;
      elapsed       <= '0;
      awaiting      <= 1'b0;
      replaced      <= 1'b0;
      send_interval <= SEND_INTERVAL_RESET;
      retry_limit   <= RETRY_LIMIT_RESET;
    end else begin
      if (cmd.exec) begin
        head     <= head_next;
        tail     <= tail_next;
        count    <= count_next;
        elapsed  <= elapsed_next;
        awaiting <= awaiting_next;
        replaced <= replaced_next;
      end
      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_SEND_INTERVAL: send_interval <= cfg_data;
          REG_RETRY_LIMIT:   retry_limit   <= cfg_data[3:0];
          default: ;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/retrying_message_send_queue_unit.sv
// Retrying transmit queue: a circular queue of QUEUE_DEPTH message handles
// with a format flag and attempt count per entry. Push appends at the tail
// (dropping the oldest when full), priority push inserts at the head
// (dropping the newest), tick advances the send timer and may issue the head
// entry, completion pops or retries the head. Each request has a load step
// that latches it and reads the head entry from the entry memory (registered
// read port), then an exec step to apply the update and load the response
// register. A new request is taken while the previous response still waits;
// a stalled response holds back only the update of the next one. The entry
// memory has no reset pass; entries are read only once written.
`default_nettype none

module retrying_message_send_queue_unit
  import rmsq_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int HANDLE_BITS = DEF_HANDLE_BITS
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      req_valid,
  output logic                           req_ready,
  input  wire req_item_t                 req,
  output logic                           rsp_valid,
  input  wire logic                      rsp_ready,
  output rsp_item_t                      rsp,
  input  wire logic                      cfg_wr_en,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_data
);

  rmsq_cmd_t cmd;

  rmsq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .cmd       (cmd)
  );

  rmsq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .req       (req),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rsp       (rsp)
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("request accepted while previous one in flight");

  a_exec_gives_rsp: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |=> rsp_valid)
    else $error("update without response");

  a_issue_pending: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.issue_send) |-> rsp.send_pending)
    else $error("send issued but not pending");

  a_pop_clears: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.popped) |-> (!rsp.send_pending && !rsp.issue_send))
    else $error("pop left send pending");

endmodule

`default_nettype wire

// File: sim/retrying_message_send_queue_unit_test.sv
`timescale 1ns / 100ps

module retrying_message_send_queue_unit_test;
  import rmsq_pkg::*;

  localparam int DEPTH = DEF_QUEUE_DEPTH;
  localparam int SLOT_BITS = $clog2(DEPTH);
  localparam int PHASES = 10;
  localparam int PHASE_REQS = 172;
  localparam int HOLD_LEN = 300;
  localparam int SETTLE = 8;
  localparam int CYCLE_LIMIT = 200000;

  typedef logic [SLOT_BITS-1:0] slot_t;
  typedef enum {MIX_FILL, MIX_EVEN, MIX_DRAIN} mix_t;
  typedef enum {ROW_REQ, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t                 kind;
    req_item_t                 item;
    logic                      typed;
    rsp_item_t                 want;
    logic [CFG_INDEX_BITS-1:0] reg_idx;
    logic [CFG_DATA_BITS-1:0]  reg_val;
  } plan_row_t;

  // per-phase register settings and request mix
  localparam int   PH_INTERVAL [PHASES] = '{1, 1, 2, 4, 65535, 1, 3, 8, 2, 1};
  localparam int   PH_LIMIT    [PHASES] = '{0, 15, 2, 1, 3, 15, 0, 5, 4, 1};
  localparam int   PH_OK_PCT   [PHASES] = '{50, 10, 40, 30, 50, 15, 60, 40, 30, 70};
  localparam mix_t PH_MIX      [PHASES] = '{MIX_EVEN, MIX_FILL, MIX_EVEN, MIX_DRAIN, MIX_FILL,
                                            MIX_EVEN, MIX_FILL, MIX_DRAIN, MIX_EVEN, MIX_DRAIN};

  logic                      clk;
  logic                      rst;
  logic                      req_valid;
  logic                      req_ready;
  req_item_t                 req;
  logic                      rsp_valid;
  logic                      rsp_ready;
  rsp_item_t                 rsp;
  logic                      cfg_wr_en;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;

  retrying_message_send_queue_unit dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // queue state as the block should hold it
  logic [15:0] slot_handle [DEPTH];
  logic        slot_html   [DEPTH];
  logic [3:0]  slot_tries  [DEPTH];
  slot_t       head_slot;
  slot_t       tail_slot;
  int          held;
  logic [15:0] tick_age;
  logic        in_flight;
  logic        head_moved;
  logic [15:0] interval_ticks;
  logic [3:0]  try_limit;

  rsp_item_t due_reports [$];

  int fault_cnt = 0;
  int n_reqs = 0;
  int n_sends = 0;
  int n_pops = 0;
  int n_drops = 0;
  int n_stale = 0;
  int cycle_cnt = 0;
  int hold_req = 0;
  logic fast_mode = 1'b0;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic void reset_queue_state();
    head_slot = '0;
    tail_slot = '0;
    held = 0;
    tick_age = '0;
    in_flight = 1'b0;
    head_moved = 1'b0;
    interval_ticks = SEND_INTERVAL_RESET;
    try_limit = RETRY_LIMIT_RESET;
  endfunction

  function automatic rsp_item_t step_send_queue(req_item_t r);
    rsp_item_t o;
    o = '0;
    case (r.opcode)
      OP_PUSH: begin
        if (held >= DEPTH) begin
          // oldest entry falls out at the head
          head_slot = head_slot + 1'b1;
          held--;
          o.dropped = 1'b1;
          if (in_flight) head_moved = 1'b1;
        end
        slot_handle[tail_slot] = r.message_handle;
        slot_html[tail_slot] = r.html_mode;
        slot_tries[tail_slot] = '0;
        tail_slot = tail_slot + 1'b1;
        held++;
      end
      OP_PRIO_PUSH: begin
        if (held >= DEPTH) begin
          tail_slot = tail_slot - 1'b1;
          held--;
          o.dropped = 1'b1;
        end
        head_slot = head_slot - 1'b1;
        slot_handle[head_slot] = r.message_handle;
        slot_html[head_slot] = r.html_mode;
        slot_tries[head_slot] = '0;
        held++;
        if (in_flight) head_moved = 1'b1;
      end
      OP_TICK: begin
        if (tick_age != TICKS_MAX) tick_age = tick_age + 1'b1;
        if (held > 0 && !in_flight && tick_age >= interval_ticks) begin
          o.issue_send = 1'b1;
          o.send_handle = slot_handle[head_slot];
          o.send_html = slot_html[head_slot];
          tick_age = '0;
          in_flight = 1'b1;
          head_moved = 1'b0;
          n_sends++;
        end
      end
      OP_COMPLETE: begin
        if (in_flight) begin
          if (head_moved) begin
            n_stale++;
          end else if (held > 0) begin
            if (r.send_ok || slot_tries[head_slot] >= try_limit) begin
              head_slot = head_slot + 1'b1;
              held--;
              o.popped = 1'b1;
              n_pops++;
            end else if (slot_tries[head_slot] != ATTEMPTS_MAX) begin
              slot_tries[head_slot] = slot_tries[head_slot] + 1'b1;
            end
          end
          in_flight = 1'b0;
          head_moved = 1'b0;
        end
      end
      default: ;
    endcase
    if (o.dropped) n_drops++;
    o.queue_count = 6'(held);
    o.send_pending = in_flight;
    return o;
  endfunction

  function automatic int idle_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic req_item_t random_req(mix_t mix, int ok_pct);
    req_item_t r;
    int roll;
    int w_push;
    int w_prio;
    int w_tick;
    case (mix)
      MIX_FILL: begin
        w_push = 50; w_prio = 15; w_tick = 20;
      end
      MIX_EVEN: begin
        w_push = 25; w_prio = 10; w_tick = 35;
      end
      default: begin
        w_push = 8; w_prio = 4; w_tick = 44;
      end
    endcase
    roll = $urandom_range(0, 99);
    r.message_handle = 16'($urandom);
    r.html_mode = 1'($urandom);
    r.send_ok = ($urandom_range(0, 99) < ok_pct);
    if (roll < w_push) r.opcode = OP_PUSH;
    else if (roll < w_push + w_prio) r.opcode = OP_PRIO_PUSH;
    else if (roll < w_push + w_prio + w_tick) r.opcode = OP_TICK;
    else r.opcode = OP_COMPLETE;
    return r;
  endfunction

  function automatic req_item_t mk_req(opcode_t op, logic [15:0] handle, logic html,
                                       logic ok);
    req_item_t r;
    r.opcode = op;
    r.message_handle = handle;
    r.html_mode = html;
    r.send_ok = ok;
    return r;
  endfunction

  function automatic rsp_item_t mk_rsp(logic issue, logic [15:0] handle, logic html,
                                       logic drop, logic pop, int count, logic pend);
    rsp_item_t o;
    o.issue_send = issue;
    o.send_handle = handle;
    o.send_html = html;
    o.dropped = drop;
    o.popped = pop;
    o.queue_count = 6'(count);
    o.send_pending = pend;
    return o;
  endfunction

  function automatic plan_row_t req_row(req_item_t it, logic typed, rsp_item_t want);
    plan_row_t p;
    p.kind = ROW_REQ;
    p.item = it;
    p.typed = typed;
    p.want = want;
    p.reg_idx = '0;
    p.reg_val = '0;
    return p;
  endfunction

  function automatic plan_row_t cfg_row(logic [CFG_INDEX_BITS-1:0] idx,
                                        logic [CFG_DATA_BITS-1:0] val);
    plan_row_t p;
    p.kind = ROW_CFG;
    p.item = '0;
    p.typed = 1'b0;
    p.want = '0;
    p.reg_idx = idx;
    p.reg_val = val;
    return p;
  endfunction

  function automatic void cmp_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h got %h", $time, name, want, got);
      fault_cnt++;
    end
  endfunction

  function automatic void take_report(rsp_item_t got);
    rsp_item_t want;
    if (due_reports.size() == 0) begin
      $display("%0t: response with no request outstanding, expected none got %h", $time, got);
      fault_cnt++;
    end else begin
      want = due_reports.pop_front();
      cmp_field("issue_send", 16'(want.issue_send), 16'(got.issue_send));
      cmp_field("send_handle", want.send_handle, got.send_handle);
      cmp_field("send_html", 16'(want.send_html), 16'(got.send_html));
      cmp_field("dropped", 16'(want.dropped), 16'(got.dropped));
      cmp_field("popped", 16'(want.popped), 16'(got.popped));
      cmp_field("queue_count", 16'(want.queue_count), 16'(got.queue_count));
      cmp_field("send_pending", 16'(want.send_pending), 16'(got.send_pending));
    end
  endfunction

  // response side: random stalls, plus one long hold on request
  initial begin : rsp_side
    int stall_left;
    int holds_done;
    stall_left = 0;
    holds_done = 0;
    rsp_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_valid === 1'b1 && rsp_ready) take_report(rsp);
      if (hold_req > holds_done) begin
        holds_done++;
        stall_left = HOLD_LEN;
      end else if (stall_left == 0 && !fast_mode && $urandom_range(0, 3) == 0) begin
        stall_left = idle_len();
      end
      if (stall_left > 0) begin
        rsp_ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  // Offer one request, hold it until taken, then book its expected response.
  task automatic offer(req_item_t it, logic typed, rsp_item_t want);
    int gap;
    rsp_item_t calc;
    gap = fast_mode ? 0 : idle_len();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req <= it;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_ready !== 1'b1) @(posedge clk);
    calc = step_send_queue(it);
    due_reports.push_back(typed ? want : calc);
    n_reqs++;
  endtask

  task automatic drain_reports();
    req_valid <= 1'b0;
    while (due_reports.size() != 0) @(posedge clk);
    // a request can still sit in the pipe; give it time to settle
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
    drain_reports();
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == REG_SEND_INTERVAL) interval_ticks = val;
    else try_limit = val[3:0];
  endtask

  initial begin : req_side
    plan_row_t plan [$];
    rsp_item_t none;
    none = '0;
    rst <= 1'b1;
    req_valid <= 1'b0;
    req <= '0;
    cfg_wr_en <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    reset_queue_state();

    // directed requests, reset settings first (interval 200, limit 2)
    plan.push_back(req_row(mk_req(OP_COMPLETE, 16'h0000, 1'b0, 1'b1), 1'b1,
                           mk_rsp(1'b0, 16'h0000, 1'b0, 1'b0, 1'b0, 0, 1'b0)));
    plan.push_back(req_row(mk_req(OP_TICK, 16'h0000, 1'b0, 1'b0), 1'b1,
                           mk_rsp(1'b0, 16'h0000, 1'b0, 1'b0, 1'b0, 0, 1'b0)));
    plan.push_back(req_row(mk_req(OP_PUSH, 16'hFFFF, 1'b1, 1'b0), 1'b1,
                           mk_rsp(1'b0, 16'h0000, 1'b0, 1'b0, 1'b0, 1, 1'b0)));
    plan.push_back(req_row(mk_req(OP_PUSH, 16'h0000, 1'b0, 1'b1), 1'b1,
                           mk_rsp(1'b0, 16'h0000, 1'b0, 1'b0, 1'b0, 2, 1'b0)));
    plan.push_back(req_row(mk_req(OP_TICK, 16'h0000, 1'b0, 1'b0), 1'b1,
                           mk_rsp(1'b0, 16'h0000, 1'b0, 1'b0, 1'b0, 2, 1'b0)));
    plan.push_back(cfg_row(REG_SEND_INTERVAL, 16'd1));
    plan.push_back(cfg_row(REG_RETRY_LIMIT, 16'd1));
    plan.push_back(req_row(mk_req(OP_TICK, 16'h0000, 1'b0, 1'b0), 1'b1,
                           mk_rsp(1'b1, 16'hFFFF, 1'b1, 1'b0, 1'b0, 2, 1'b1)));
    // tick while the send is out: nothing issued
    plan.push_back(req_row(mk_req(OP_TICK, 16'h0000, 1'b0, 1'b0), 1'b1,
                           mk_rsp(1'b0, 16'h0000, 1'b0, 1'b0, 1'b0, 2, 1'b1)));
    plan.push_back(req_row(mk_req(OP_COMPLETE, 16'h0000, 1'b0, 1'b0), 1'b1,
                           mk_rsp(1'b0, 16'h0000, 1'b0, 1'b0, 1'b0, 2, 1'b0)));
    plan.push_back(req_row(mk_req(OP_TICK, 16'h0000, 1'b0, 1'b0), 1'b1,
                           mk_rsp(1'b1, 16'hFFFF, 1'b1, 1'b0, 1'b0, 2, 1'b1)));
    // second failure reaches the limit: entry is discarded
    plan.push_back(req_row(mk_req(OP_COMPLETE, 16'h0000, 1'b0, 1'b0), 1'b1,
                           mk_rsp(1'b0, 16'h0000, 1'b0, 1'b0, 1'b1, 1, 1'b0)));
    plan.push_back(req_row(mk_req(OP_TICK, 16'h0000, 1'b0, 1'b0), 1'b1,
                           mk_rsp(1'b1, 16'h0000, 1'b0, 1'b0, 1'b0, 1, 1'b1)));
    // priority push during a send replaces the head; completion is stale
    plan.push_back(req_row(mk_req(OP_PRIO_PUSH, 16'hAAAA, 1'b1, 1'b0), 1'b1,
                           mk_rsp(1'b0, 16'h0000, 1'b0, 1'b0, 1'b0, 2, 1'b1)));
    plan.push_back(req_row(mk_req(OP_COMPLETE, 16'h0000, 1'b0, 1'b1), 1'b1,
                           mk_rsp(1'b0, 16'h0000, 1'b0, 1'b0, 1'b0, 2, 1'b0)));
    plan.push_back(req_row(mk_req(OP_TICK, 16'h0000, 1'b0, 1'b0), 1'b1,
                           mk_rsp(1'b1, 16'hAAAA, 1'b1, 1'b0, 1'b0, 2, 1'b1)));
    plan.push_back(req_row(mk_req(OP_COMPLETE, 16'hFFFF, 1'b1, 1'b1), 1'b1,
                           mk_rsp(1'b0, 16'h0000, 1'b0, 1'b0, 1'b1, 1, 1'b0)));
    plan.push_back(cfg_row(REG_SEND_INTERVAL, 16'hFFFF));
    plan.push_back(cfg_row(REG_RETRY_LIMIT, 16'd15));
    plan.push_back(req_row(mk_req(OP_TICK, 16'h1234, 1'b1, 1'b1), 1'b0, none));
    plan.push_back(req_row(mk_req(OP_PUSH, 16'h5A5A, 1'b0, 1'b0), 1'b0, none));
    plan.push_back(req_row(mk_req(OP_PRIO_PUSH, 16'hA5A5, 1'b1, 1'b1), 1'b0, none));
    plan.push_back(req_row(mk_req(OP_COMPLETE, 16'h0F0F, 1'b0, 1'b0), 1'b0, none));

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) write_reg(plan[i].reg_idx, plan[i].reg_val);
      else offer(plan[i].item, plan[i].typed, plan[i].want);
    end

    for (int p = 0; p < PHASES; p++) begin
      write_reg(REG_SEND_INTERVAL, 16'(PH_INTERVAL[p]));
      write_reg(REG_RETRY_LIMIT, (p == 8) ? 16'($urandom_range(0, 15)) : 16'(PH_LIMIT[p]));
      if (p == 1) hold_req <= hold_req + 1;   // long output stall while filling
      if (p == 5) fast_mode <= 1'b1;
      if (p == 6) fast_mode <= 1'b0;
      for (int k = 0; k < PHASE_REQS; k++) offer(random_req(PH_MIX[p], PH_OK_PCT[p]), 1'b0, none);
    end

    req_valid <= 1'b0;
    while (due_reports.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("Ran %0d requests over %0d register settings: %0d sends, %0d pops,",
             n_reqs, PHASES + 3, n_sends, n_pops);
    $display("%0d drops, %0d stale completions, %0d mismatches.", n_drops, n_stale, fault_cnt);
    if (fault_cnt == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
